[hdl/stdr_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp package
// Widths, register indexes, phase codes and the command and status groups
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package stdr_pkg;

  // Field widths.
  localparam int STEP_COUNT_BITS = 20;
  localparam int DELAY_BITS      = 32;
  localparam int DELAY_FRAC_BITS = 16;
  localparam int PHASE_BITS      = 2;

  // Divider sizes: the dividend is twice the delay, the divisor is 4n+1 or 4n-1.
  localparam int DIVIDEND_BITS = DELAY_BITS + 1;
  localparam int DIVISOR_BITS  = STEP_COUNT_BITS + 2;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // Stream widths: item fields packed from bit zero, padded to whole bytes.
  localparam int S_TDATA_BITS = 8;
  localparam int M_TDATA_BITS = 56;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_STEPS  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINEAR_STEPS = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECEL_STEPS  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_STEPS  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_DELAY  = 3'd4;

  // Reset value of the delay: one whole unit.
  localparam logic [DELAY_BITS-1:0] DELAY_ONE = DELAY_BITS'(1) << DELAY_FRAC_BITS;

  // Ramp phase codes as reported on the output.
  typedef enum logic [PHASE_BITS-1:0] {
    PHASE_ACCEL = 2'd0,
    PHASE_CONST = 2'd1,
    PHASE_DECEL = 2'd2
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic eval;    // choose phase, advance counters, start divider
    logic finish;  // form the result and load the output register
  } stdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_div;  // no division needed for this item
    logic div_done;  // quotient is ready
    logic out_free;  // output register can take a result
  } stdr_status_t;

endpackage

[hdl/stdr_div.sv]
// ----------------------------------------------------------------------------
// Stepper ramp divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stdr_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [stdr_pkg::DIVIDEND_BITS-1:0]     dividend,
  input  logic [stdr_pkg::DIVISOR_BITS-1:0]      divisor,
  output logic [stdr_pkg::DIVIDEND_BITS-1:0]     quotient,
  output logic                                   done
);

  logic [stdr_pkg::DIVISOR_BITS-1:0]  rem;
  logic [stdr_pkg::DIVIDEND_BITS-1:0] quo;
  logic [stdr_pkg::DIVISOR_BITS-1:0]  dsr;
  logic [stdr_pkg::DIV_CNT_BITS-1:0]  cnt;
  logic                               busy;
  logic [stdr_pkg::DIVISOR_BITS:0]    trial;
  logic [stdr_pkg::DIVISOR_BITS:0]    diff;
  logic                               fits;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, quo[stdr_pkg::DIVIDEND_BITS-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == stdr_pkg::DIV_CNT_BITS'(stdr_pkg::DIVIDEND_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[stdr_pkg::DIVISOR_BITS-1:0] : trial[stdr_pkg::DIVISOR_BITS-1:0];
      quo <= {quo[stdr_pkg::DIVIDEND_BITS-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

[hdl/stdr_dp.sv]
// ----------------------------------------------------------------------------
// Stepper ramp datapath
// Configuration registers, move state, phase choice, divider and the
// output register.
// ----------------------------------------------------------------------------
module stdr_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [stdr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [stdr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  start_move,
  input  stdr_pkg::stdr_cmd_t                   cmd,
  output stdr_pkg::stdr_status_t                st,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [stdr_pkg::M_TDATA_BITS-1:0]     m_tdata
);

  localparam int CB = stdr_pkg::STEP_COUNT_BITS;
  localparam int DB = stdr_pkg::DELAY_BITS;

  // Configuration registers.
  logic [CB-1:0] accel_steps;
  logic [CB-1:0] linear_steps;
  logic [CB-1:0] decel_steps;
  logic [CB-1:0] total_steps;
  logic [DB-1:0] first_delay;

  // Move state; the down index is kept as its magnitude.
  logic [CB-1:0] position_count;
  logic [CB-1:0] ramp_up_index;
  logic [CB-1:0] ramp_down_mag;
  logic [DB-1:0] current_delay;

  // Per-item registers.
  logic                  item_done;
  stdr_pkg::phase_t      item_phase;
  logic [CB-1:0]         item_number;
  logic                  item_last;

  // Output register.
  logic [stdr_pkg::M_TDATA_BITS-1:0] out_data;

  // Evaluation signals.
  logic                                done_now;
  logic [CB-1:0]                       pos_next;
  logic [CB-1:0]                       up_next;
  logic [CB-1:0]                       mag_next;
  logic [CB:0]                         const_end;
  stdr_pkg::phase_t                    phase_now;
  logic [stdr_pkg::DIVISOR_BITS-1:0]   divisor;
  logic                                div_start;
  logic [stdr_pkg::DIVIDEND_BITS-1:0]  quotient;
  logic                                div_done;

  // Result forming.
  logic [DB:0]   decel_sum;
  logic [DB-1:0] nd;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_steps  <= '0;
      linear_steps <= '0;
      decel_steps  <= CB'(1);
      total_steps  <= '0;
      first_delay  <= stdr_pkg::DELAY_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        stdr_pkg::REG_ACCEL_STEPS:  accel_steps  <= cfg_data[CB-1:0];
        stdr_pkg::REG_LINEAR_STEPS: linear_steps <= cfg_data[CB-1:0];
        stdr_pkg::REG_DECEL_STEPS:  decel_steps  <= cfg_data[CB-1:0];
        stdr_pkg::REG_TOTAL_STEPS:  total_steps  <= cfg_data[CB-1:0];
        stdr_pkg::REG_FIRST_DELAY:  first_delay  <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  // Phase choice and divisor for the step being evaluated.
  always_comb begin
    done_now  = (position_count >= total_steps);
    pos_next  = position_count + 1'b1;
    up_next   = ramp_up_index + 1'b1;
    mag_next  = (ramp_down_mag <= CB'(1)) ? CB'(1) : ramp_down_mag - 1'b1;
    const_end = {1'b0, accel_steps} + {1'b0, linear_steps};
    if (pos_next < accel_steps) begin
      phase_now = stdr_pkg::PHASE_ACCEL;
    end else if ({1'b0, pos_next} < const_end) begin
      phase_now = stdr_pkg::PHASE_CONST;
    end else begin
      phase_now = stdr_pkg::PHASE_DECEL;
    end
    // 4n+1 while accelerating, 4|m|-1 while decelerating.
    if (phase_now == stdr_pkg::PHASE_ACCEL) begin
      divisor = {up_next, 2'b01};
    end else begin
      divisor = {mag_next, 2'b00} - 1'b1;
    end
    div_start = cmd.eval && !done_now && (phase_now != stdr_pkg::PHASE_CONST);
  end

  stdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({current_delay, 1'b0}),
    .divisor  (divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  // Move state: restart on an accept with start_move, advance on evaluate, new delay on finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      ramp_up_index  <= '0;
      ramp_down_mag  <= CB'(1);
      current_delay  <= stdr_pkg::DELAY_ONE;
    end else if (cmd.accept) begin
      if (start_move) begin
        position_count <= '0;
        ramp_up_index  <= '0;
        ramp_down_mag  <= decel_steps;
        current_delay  <= first_delay;
      end
    end else if (cmd.eval) begin
      if (!done_now) begin
        position_count <= pos_next;
        if (phase_now == stdr_pkg::PHASE_ACCEL) begin
          ramp_up_index <= up_next;
        end
        if (phase_now == stdr_pkg::PHASE_DECEL) begin
          ramp_down_mag <= mag_next;
        end
      end
    end else if (cmd.finish) begin
      if (!item_done) begin
        current_delay <= nd;
      end
    end
  end

  // Per-item facts captured at evaluation.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      item_done   <= done_now;
      item_phase  <= done_now ? stdr_pkg::PHASE_ACCEL : phase_now;
      item_number <= done_now ? position_count : pos_next;
      item_last   <= done_now || (pos_next == total_steps);
    end
  end

  // New delay from the quotient.
  always_comb begin
    decel_sum = {1'b0, current_delay} + {1'b0, quotient[DB-1:0]};
    case (item_phase)
      stdr_pkg::PHASE_ACCEL: nd = current_delay - quotient[DB-1:0];
      stdr_pkg::PHASE_DECEL: nd = decel_sum[DB] ? {DB{1'b1}} : decel_sum[DB-1:0];
      default:               nd = current_delay;
    endcase
  end

  // Output register: fields from bit zero are step_taken, step_delay,
  // ramp_phase, step_number, move_done.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {item_last, item_number, item_phase,
                   item_done ? {DB{1'b0}} : nd, !item_done};
    end
  end

  assign m_tdata     = out_data;
  assign st.skip_div = done_now || (phase_now == stdr_pkg::PHASE_CONST);
  assign st.div_done = div_done;
  assign st.out_free = !m_tvalid || m_tready;

endmodule

[hdl/stdr_ctrl.sv]
// ----------------------------------------------------------------------------
// Stepper ramp controller
// Sequences one item at a time: accept, evaluate, divide, hand over.
// ----------------------------------------------------------------------------
module stdr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  stdr_pkg::stdr_status_t  st,
  output stdr_pkg::stdr_cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = st.skip_div ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/stepper_trapezoid_step_delay_ramp.sv]
// ----------------------------------------------------------------------------
// Stepper trapezoid step delay ramp
// Produces the delay before each step of a trapezoidal or triangular move.
// ----------------------------------------------------------------------------
// Each input item advances the move by one step, unless the move is complete,
// and returns one result item. An acceleration or deceleration step goes
// through the accept and evaluate cycles, the divider steps, the cycle in
// which the controller sees the divider finish, and the finish cycle that
// loads the output register. The result is offered on m_tvalid in the cycle
// after that. A constant-speed step, or an item after the move is complete,
// goes through accept, evaluate and finish. The bit-serial divider forms
// 2c/(4n+1), or 2c/(4n-1) while decelerating, one quotient bit per cycle. The
// next item is accepted in the cycle after finish. Only one item is worked on
// at a time. The output register holds a finished result, so the next item can
// be accepted while that result waits to be taken. A finish waits while an
// earlier result has not been taken. The user must write registers through the
// cfg port while the block is idle; the block does not enforce this.
// decel_steps and first_delay take effect at the next item with start_move.
module stepper_trapezoid_step_delay_ramp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [stdr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [stdr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [0] start_move, [7:1] zero
  input  logic [stdr_pkg::S_TDATA_BITS-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] step_taken, [32:1] step_delay, [34:33] ramp_phase,
  // [54:35] step_number, [55] move_done
  output logic [stdr_pkg::M_TDATA_BITS-1:0]    m_tdata
);

  stdr_pkg::stdr_cmd_t    cmd;
  stdr_pkg::stdr_status_t st;

  stdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  stdr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_move (s_tdata[0]),
    .cmd        (cmd),
    .st         (st),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
